// ----- rtl/core/tnl_pkg.sv -----
// Shared types and constants for the largest-entry tracker.
// Used by tnl_front, tnl_back and top_n_largest_tracker; depends on nothing.
`default_nettype none

package tnl_pkg;

   localparam int MAX_KEEP_DEF = 16;
   localparam int SIZE_WIDTH   = 64;
   localparam int TAG_WIDTH    = 32;
   localparam int KEEP_WIDTH   = 5;
   localparam int RANK_WIDTH   = 4;
   localparam logic [KEEP_WIDTH-1:0] KEEP_RESET = 5'd10;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_OFFER = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [SIZE_WIDTH-1:0] item_size;
      logic [TAG_WIDTH-1:0]  item_tag;
   } req_item_type;

   typedef struct packed {
      logic                  out_valid;
      logic [SIZE_WIDTH-1:0] entry_size;
      logic [TAG_WIDTH-1:0]  out_tag;
      logic [RANK_WIDTH-1:0] out_rank;
      logic                  out_last;
   } rsp_item_type;

   typedef enum logic {
      BK_RUN,
      BK_DRAIN
   } back_state_type;

endpackage : tnl_pkg

`default_nettype wire

// ----- rtl/core/tnl_front.sv -----
// Front end of the tracker: takes items on the start/busy handshake and queues them.
// Depends on tnl_pkg.
`default_nettype none

module tnl_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire tnl_pkg::req_item_type req_item,
   output logic                       busy,
   output logic                       cmd_valid,
   output tnl_pkg::req_item_type      cmd_item,
   input  wire logic                  cmd_pop
);
   import tnl_pkg::*;

   req_item_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, cmd_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule : tnl_front

`default_nettype wire

// ----- rtl/core/tnl_back.sv -----
// Back end of the tracker: sorted chain of compare-and-shift cells, drain sequencer,
// keep_count register and registered result port. Depends on tnl_pkg.
`default_nettype none

module tnl_back #(
   parameter int MAX_KEEP = tnl_pkg::MAX_KEEP_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              cmd_valid,
   input  wire tnl_pkg::req_item_type             cmd_item,
   output logic                                   cmd_pop,
   input  wire logic                              csr_we,
   input  wire logic [tnl_pkg::KEEP_WIDTH-1:0]    csr_wdata,
   output logic                                   rsp_strobe,
   output tnl_pkg::rsp_item_type                  rsp_item
);
   import tnl_pkg::*;

   localparam int FILL_W = $clog2(MAX_KEEP + 1);
   localparam int IDX_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   logic [SIZE_WIDTH-1:0] slot_size_ff [MAX_KEEP];
   logic [SIZE_WIDTH-1:0] slot_size_in [MAX_KEEP];
   logic [TAG_WIDTH-1:0]  slot_tag_ff  [MAX_KEEP];
   logic [TAG_WIDTH-1:0]  slot_tag_in  [MAX_KEEP];

   back_state_type        state_ff, state_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [KEEP_WIDTH-1:0] keep_ff, keep_in;
   logic [RANK_WIDTH-1:0] rank_ff, rank_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   logic [FILL_W-1:0]     lim, lim_m1, csr_lim, n_eff;
   logic                  room, insert;
   logic [MAX_KEEP-1:0]   lt, take;

   // saturate the register into 1..MAX_KEEP
   function automatic logic [FILL_W-1:0] clamp_keep(input logic [KEEP_WIDTH-1:0] k);
      logic [FILL_W-1:0] r;
      if (k == '0) begin
         r = FILL_W'(1);
      end else if (int'(k) > MAX_KEEP) begin
         r = FILL_W'(MAX_KEEP);
      end else begin
         r = FILL_W'(k);
      end
      return r;
   endfunction

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      lim     = clamp_keep(keep_ff);
      lim_m1  = lim - FILL_W'(1);
      csr_lim = clamp_keep(csr_wdata);
      room    = (fill_ff < lim);
      n_eff   = room ? fill_ff : lim_m1;
      for (int i = 0; i < MAX_KEEP; i++) begin
         lt[i]   = (slot_size_ff[i] < cmd_item.item_size);
         // first cell whose entry is smaller takes the new item; ties go after
         take[i] = (FILL_W'(i) < n_eff) ? lt[i] : 1'b1;
      end
      insert = room || lt[lim_m1[IDX_W-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      keep_in       = keep_ff;
      rank_in       = rank_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      cmd_pop       = 1'b0;
      slot_size_in  = slot_size_ff;
      slot_tag_in   = slot_tag_ff;

      unique case (state_ff)
         BK_RUN: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_item.req_type == REQ_DRAIN) begin
                  if (fill_ff == '0) begin
                     rsp_strobe_in         = 1'b1;
                     rsp_item_in           = '0;
                     rsp_item_in.out_last  = 1'b1;
                  end else begin
                     rank_in  = '0;
                     state_in = BK_DRAIN;
                  end
               end else if (insert) begin
                  if (take[0]) begin
                     slot_size_in[0] = cmd_item.item_size;
                     slot_tag_in[0]  = cmd_item.item_tag;
                  end
                  for (int i = 1; i < MAX_KEEP; i++) begin
                     if (take[i-1]) begin
                        slot_size_in[i] = slot_size_ff[i-1];
                        slot_tag_in[i]  = slot_tag_ff[i-1];
                     end else if (take[i]) begin
                        slot_size_in[i] = cmd_item.item_size;
                        slot_tag_in[i]  = cmd_item.item_tag;
                     end
                  end
                  if (room) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         BK_DRAIN: begin
            // emit the head cell and advance the chain towards it
            rsp_strobe_in          = 1'b1;
            rsp_item_in.out_valid  = 1'b1;
            rsp_item_in.entry_size = slot_size_ff[0];
            rsp_item_in.out_tag    = slot_tag_ff[0];
            rsp_item_in.out_rank   = rank_ff;
            rsp_item_in.out_last   = (fill_ff == FILL_W'(1));
            for (int i = 0; i < MAX_KEEP - 1; i++) begin
               slot_size_in[i] = slot_size_ff[i+1];
               slot_tag_in[i]  = slot_tag_ff[i+1];
            end
            fill_in = fill_ff - FILL_W'(1);
            rank_in = rank_ff + RANK_WIDTH'(1);
            if (fill_ff == FILL_W'(1)) begin
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase

      // shrinking the limit drops the smallest entries at once
      if (csr_we) begin
         keep_in = csr_wdata;
         if (fill_ff > csr_lim) begin
            fill_in = csr_lim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_RUN;
         fill_ff       <= '0;
         keep_ff       <= KEEP_RESET;
         rank_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         keep_ff       <= keep_in;
         rank_ff       <= rank_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      slot_size_ff <= slot_size_in;
      slot_tag_ff  <= slot_tag_in;
   end

endmodule : tnl_back

`default_nettype wire

// ----- rtl/core/top_n_largest_tracker.sv -----
// Top level of the largest-entry tracker: command queue front end and sorted cell chain.
// Depends on tnl_pkg, tnl_front and tnl_back.
//
//   channel   ports                    handshake
//   request   start, busy, req_item    taken when start is high and busy is low
//   result    rsp_strobe, rsp_item     each item shown for a single cycle, cannot be held off
//   config    csr_we, csr_wdata        written when csr_we is high
//
// Results leave from a register. The cell chain sorts an offer in place; a drain
// first enters the drain state, then shifts the kept entries out of the head cell;
// an empty drain gives a single result with only out_last set. A two-entry queue
// sits in front, so busy rises only while a drain holds the chain and the queue has
// filled. Reset empties the store and the queue and sets keep_count to 10.

`default_nettype none

module top_n_largest_tracker #(
   parameter int MAX_KEEP = tnl_pkg::MAX_KEEP_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire tnl_pkg::req_item_type          req_item,
   output logic                                busy,
   output logic                                rsp_strobe,
   output tnl_pkg::rsp_item_type               rsp_item,
   input  wire logic                           csr_we,
   input  wire logic [tnl_pkg::KEEP_WIDTH-1:0] csr_wdata
);
   import tnl_pkg::*;

   logic         cmd_valid;
   logic         cmd_pop;
   req_item_type cmd_item;

   tnl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop)
   );

   tnl_back #(
      .MAX_KEEP (MAX_KEEP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_item   (cmd_item),
      .cmd_pop    (cmd_pop),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule : top_n_largest_tracker

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for top_n_largest_tracker: directed and random offers and drains,
// each drain checked against a bench-side model of the sorted store.
// Depends on tnl_pkg and the tracker RTL.

module tb;
   import tnl_pkg::*;

   localparam int KEEP_MAX     = MAX_KEEP_DEF;
   localparam int QUIET_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   req_item_type          req_item  = '0;
   logic                  busy;
   logic                  rsp_strobe;
   rsp_item_type          rsp_item;
   logic                  csr_we    = 1'b0;
   logic [KEEP_WIDTH-1:0] csr_wdata = '0;

   // bench copy of the store: slot 0 holds the largest entry
   logic [SIZE_WIDTH-1:0] kept_size [KEEP_MAX];
   logic [TAG_WIDTH-1:0]  kept_tag  [KEEP_MAX];
   int                    kept_fill;
   logic [KEEP_WIDTH-1:0] keep_reg;

   rsp_item_type pending_rsp [$];
   rsp_item_type want_rsp;
   bit           steady = 1'b0;
   bit           failed = 1'b0;
   int           cycle_count = 0;

   top_n_largest_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int keep_limit();
      if (keep_reg < 1) return 1;
      if (keep_reg > KEEP_MAX) return KEEP_MAX;
      return int'(keep_reg);
   endfunction

   // place after every kept entry of equal size, so ties keep arrival order
   function automatic void insert_sorted(int n, logic [SIZE_WIDTH-1:0] size,
                                         logic [TAG_WIDTH-1:0] tag);
      int pos = 0;
      while (pos < n && kept_size[pos] >= size) pos++;
      for (int i = n; i > pos; i--) begin
         kept_size[i] = kept_size[i-1];
         kept_tag[i]  = kept_tag[i-1];
      end
      kept_size[pos] = size;
      kept_tag[pos]  = tag;
   endfunction

   function automatic void predict_ranking(req_item_type it);
      int           lim;
      rsp_item_type r;
      lim = keep_limit();
      if (kept_fill > lim) kept_fill = lim;
      if (it.req_type == REQ_OFFER) begin
         if (kept_fill < lim) begin
            insert_sorted(kept_fill, it.item_size, it.item_tag);
            kept_fill++;
         end else if (it.item_size > kept_size[lim-1]) begin
            // drop the latest-arrived minimum
            insert_sorted(lim - 1, it.item_size, it.item_tag);
         end
      end else if (kept_fill == 0) begin
         r          = '0;
         r.out_last = 1'b1;
         pending_rsp.push_back(r);
      end else begin
         for (int i = 0; i < kept_fill; i++) begin
            r.out_valid  = 1'b1;
            r.entry_size = kept_size[i];
            r.out_tag    = kept_tag[i];
            r.out_rank   = RANK_WIDTH'(i);
            r.out_last   = (i == kept_fill - 1);
            pending_rsp.push_back(r);
         end
         kept_fill = 0;
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_item);
            failed = 1'b1;
         end else begin
            want_rsp = pending_rsp.pop_front();
            check_field("out_valid", 64'(want_rsp.out_valid), 64'(rsp_item.out_valid));
            check_field("entry_size", want_rsp.entry_size, rsp_item.entry_size);
            check_field("out_tag", 64'(want_rsp.out_tag), 64'(rsp_item.out_tag));
            check_field("out_rank", 64'(want_rsp.out_rank), 64'(rsp_item.out_rank));
            check_field("out_last", 64'(want_rsp.out_last), 64'(rsp_item.out_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_rsp.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // hold the item until busy is low at a rising edge
   task automatic send_item(input req_item_type it);
      while (!steady && $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_ranking(it);
   endtask

   task automatic offer(input logic [SIZE_WIDTH-1:0] size, input logic [TAG_WIDTH-1:0] tag);
      req_item_type it;
      it.req_type  = REQ_OFFER;
      it.item_size = size;
      it.item_tag  = tag;
      send_item(it);
   endtask

   // operands of a drain are junk on purpose
   task automatic drain();
      req_item_type it;
      it.req_type  = REQ_DRAIN;
      it.item_size = {$urandom, $urandom};
      it.item_tag  = $urandom;
      send_item(it);
   endtask

   task automatic wait_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // offers give no result, so allow the queue and chain to settle as well
   task automatic wait_quiet();
      wait_results();
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(input logic [KEEP_WIDTH-1:0] value);
      int lim;
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we   <= 1'b0;
      keep_reg = value;
      lim      = keep_limit();
      if (kept_fill > lim) kept_fill = lim;
   endtask

   task automatic test_empty_drain();
      drain();
   endtask

   task automatic test_extremes();
      offer('0, '0);
      offer('1, '1);
      offer(64'd7, 32'hA1);
      offer(64'd7, 32'hA2);
      offer(64'd7, 32'hA3);
      offer(64'h8000_0000_0000_0000, 32'h8000_0000);
      drain();
   endtask

   task automatic test_tie_eviction();
      write_keep(5'd2);
      offer(64'd5, 32'h11);
      offer(64'd5, 32'h12);
      offer(64'd5, 32'h13);
      offer(64'd3, 32'h14);
      offer(64'd6, 32'h15);
      drain();
   endtask

   task automatic test_shrink();
      write_keep(5'd4);
      offer(64'd9, 32'h21);
      offer(64'd4, 32'h22);
      offer(64'd7, 32'h23);
      offer(64'd1, 32'h24);
      write_keep(5'd2);
      drain();
   endtask

   task automatic test_keep_saturation();
      write_keep(5'd0);
      offer(64'd2, 32'h31);
      offer(64'd8, 32'h32);
      drain();
   endtask

   // mostly runs of offers closed by a drain; some runs are cut short
   task automatic run_random_phase(input logic [KEEP_WIDTH-1:0] keep_value, input int count);
      int                    offers_left;
      int                    hold_at;
      logic [SIZE_WIDTH-1:0] size;
      write_keep(keep_value);
      offers_left = $urandom_range(0, 24);
      hold_at     = $urandom_range(0, count - 1);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) wait_results();
         if (offers_left == 0 || $urandom_range(0, 19) == 0) begin
            drain();
            offers_left = $urandom_range(0, 24);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: size = SIZE_WIDTH'($urandom_range(0, 7));
               4, 5:       size = {$urandom, $urandom};
               6:          size = $urandom_range(0, 1) ? '1 : '0;
               default:    size = SIZE_WIDTH'($urandom_range(0, 1000));
            endcase
            offer(size, $urandom);
            offers_left--;
         end
      end
   endtask

   task automatic test_random();
      logic [KEEP_WIDTH-1:0] keeps [8];
      keeps = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd10, 5'd2, 5'd9};
      keeps[6] = KEEP_WIDTH'($urandom_range(2, 15));
      keeps[7] = KEEP_WIDTH'($urandom_range(2, 15));
      for (int p = 0; p < 8; p++) begin
         steady = (p == 2);
         run_random_phase(keeps[p], 50);
      end
      steady = 1'b0;
   endtask

   initial begin
      kept_fill = 0;
      keep_reg  = KEEP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_drain();
      test_extremes();
      test_tie_eviction();
      test_shrink();
      test_keep_saturation();
      test_random();
      wait_quiet();
      if (!failed) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
